// ----- hdl/indexed_sequence_store_assert.svh -----
// Assertion macros used by the indexed sequence store RTL.
// Included by files that carry concurrent checks; needs no package.
`ifndef INDEXED_SEQUENCE_STORE_ASSERT_SVH
`define INDEXED_SEQUENCE_STORE_ASSERT_SVH

// same-cycle implication
`define ISS_ASSERT_IMP(lbl, ck, rs, ant, con) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ant) |-> (con)) \
    else $error("same-cycle check failed");

// next-cycle implication
`define ISS_ASSERT_NXT(lbl, ck, rs, ant, con) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ant) |=> (con)) \
    else $error("next-cycle check failed");

`endif

// ----- hdl/iss_pkg.sv -----
// Package for the indexed sequence store: request and status codes,
// result beat type and fixed constants. No dependencies.
`timescale 1ns / 1ps

package iss_pkg;

  typedef enum logic [2:0] {
    RQ_INS_HEAD = 3'd0,
    RQ_INS_TAIL = 3'd1,
    RQ_INS_AT   = 3'd2,
    RQ_RD_AT    = 3'd3,
    RQ_DEL_HEAD = 3'd4,
    RQ_DEL_TAIL = 3'd5,
    RQ_DEL_AT   = 3'd6
  } req_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned POS_W   = 9;
  localparam int unsigned COUNT_W = 9;

  localparam logic [DATA_W-1:0] BAD_READ_VALUE = 32'd1000;

  typedef struct packed {
    status_t             status;
    logic [DATA_W-1:0]   data;
    logic [COUNT_W-1:0]  count;
  } res_t;

endpackage

// ----- hdl/iss_mem.sv -----
// Value memory of the indexed sequence store: one write port and one
// read port with registered read data. Depends on iss_pkg.
`timescale 1ns / 1ps

module iss_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [AW-1:0]                 wr_addr,
  input  logic [iss_pkg::DATA_W-1:0]    wr_data,
  input  logic                          rd_en,
  input  logic [AW-1:0]                 rd_addr,
  output logic [iss_pkg::DATA_W-1:0]    rd_data
);

  logic [iss_pkg::DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hdl/iss_ctrl.sv -----
// Request sequencer of the indexed sequence store: decodes a beat, checks
// it against the count and walks the memory to shift entries.
// Depends on iss_pkg, iss_mem port timing and the assertion header.
`timescale 1ns / 1ps
`include "indexed_sequence_store_assert.svh"

module iss_ctrl #(
  parameter int unsigned CAPACITY = 256,
  parameter int unsigned AW       = 8,
  parameter int unsigned CW       = 9
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [2:0]                    req_type,
  input  logic [iss_pkg::POS_W-1:0]     position,
  input  logic [iss_pkg::DATA_W-1:0]    data_in,
  output logic                          res_valid,
  input  logic                          res_take,
  output iss_pkg::res_t                 res,
  output logic                          mem_wr,
  output logic [AW-1:0]                 mem_wr_addr,
  output logic [iss_pkg::DATA_W-1:0]    mem_wr_data,
  output logic                          mem_rd,
  output logic [AW-1:0]                 mem_rd_addr,
  input  logic [iss_pkg::DATA_W-1:0]    mem_rd_data
);

  localparam int unsigned PW = (CW > iss_pkg::POS_W) ? CW : iss_pkg::POS_W;
  localparam logic [PW-1:0] CAP_E = PW'(CAPACITY);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_SHIFT_UP = 6'b000010,
    S_INS_WR   = 6'b000100,
    S_SHIFT_DN = 6'b001000,
    S_READ     = 6'b010000,
    S_DONE     = 6'b100000
  } state_t;

  state_t                      state, state_next;
  logic [CW-1:0]               cnt, cnt_next;
  logic [AW-1:0]               idx, idx_next;
  logic [AW-1:0]               tgt, tgt_next;
  logic [iss_pkg::DATA_W-1:0]  val, val_next;
  iss_pkg::status_t            res_status, res_status_next;
  logic [iss_pkg::DATA_W-1:0]  res_data, res_data_next;

  logic [PW-1:0]               pos_e, cnt_e, ins_pos_e, del_pos_e, last_e;
  logic [AW-1:0]               last;
  iss_pkg::req_t               req;

  assign req   = iss_pkg::req_t'(req_type);
  assign pos_e = PW'(position);
  assign cnt_e = PW'(cnt);
  assign last_e = cnt_e - PW'(1);
  assign last  = AW'(cnt - CW'(1));

  always_comb begin
    unique case (req)
      iss_pkg::RQ_INS_HEAD: ins_pos_e = '0;
      iss_pkg::RQ_INS_TAIL: ins_pos_e = cnt_e;
      default:              ins_pos_e = pos_e;
    endcase
    unique case (req)
      iss_pkg::RQ_DEL_HEAD: del_pos_e = '0;
      iss_pkg::RQ_DEL_TAIL: del_pos_e = last_e;
      default:              del_pos_e = pos_e;
    endcase
  end

  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    idx_next        = idx;
    tgt_next        = tgt;
    val_next        = val;
    res_status_next = res_status;
    res_data_next   = res_data;
    mem_wr          = 1'b0;
    mem_wr_addr     = idx;
    mem_wr_data     = mem_rd_data;
    mem_rd          = 1'b0;
    mem_rd_addr     = idx;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          val_next        = data_in;
          res_status_next = iss_pkg::ST_OK;
          res_data_next   = '0;
          state_next      = S_DONE;
          unique case (req)
            iss_pkg::RQ_INS_HEAD, iss_pkg::RQ_INS_TAIL, iss_pkg::RQ_INS_AT: begin
              if (ins_pos_e > cnt_e) begin
                res_status_next = iss_pkg::ST_BADPOS;
              end else if (cnt_e == CAP_E) begin
                res_status_next = iss_pkg::ST_FULL;
              end else if (ins_pos_e == cnt_e) begin
                mem_wr      = 1'b1;
                mem_wr_addr = AW'(ins_pos_e);
                mem_wr_data = data_in;
                cnt_next    = cnt + CW'(1);
              end else begin
                mem_rd      = 1'b1;
                mem_rd_addr = last;
                idx_next    = last;
                tgt_next    = AW'(ins_pos_e);
                state_next  = S_SHIFT_UP;
              end
            end
            iss_pkg::RQ_RD_AT: begin
              if (pos_e < cnt_e) begin
                mem_rd      = 1'b1;
                mem_rd_addr = AW'(pos_e);
                state_next  = S_READ;
              end else begin
                res_status_next = iss_pkg::ST_BADPOS;
                res_data_next   = iss_pkg::BAD_READ_VALUE;
              end
            end
            iss_pkg::RQ_DEL_HEAD, iss_pkg::RQ_DEL_TAIL, iss_pkg::RQ_DEL_AT: begin
              if (req != iss_pkg::RQ_DEL_AT && cnt_e == '0) begin
                res_status_next = iss_pkg::ST_EMPTY;
              end else if (req == iss_pkg::RQ_DEL_AT && pos_e >= cnt_e) begin
                res_status_next = iss_pkg::ST_BADPOS;
              end else if (del_pos_e == last_e) begin
                cnt_next = cnt - CW'(1);
              end else begin
                mem_rd      = 1'b1;
                mem_rd_addr = AW'(del_pos_e + PW'(1));
                idx_next    = AW'(del_pos_e + PW'(1));
                state_next  = S_SHIFT_DN;
              end
            end
            default: begin
              res_status_next = iss_pkg::ST_BADPOS;
            end
          endcase
        end
      end
      S_SHIFT_UP: begin
        mem_wr      = 1'b1;
        mem_wr_addr = idx + AW'(1);
        if (idx == tgt) begin
          state_next = S_INS_WR;
        end else begin
          mem_rd      = 1'b1;
          mem_rd_addr = idx - AW'(1);
          idx_next    = idx - AW'(1);
        end
      end
      S_INS_WR: begin
        mem_wr      = 1'b1;
        mem_wr_addr = tgt;
        mem_wr_data = val;
        cnt_next    = cnt + CW'(1);
        state_next  = S_DONE;
      end
      S_SHIFT_DN: begin
        mem_wr      = 1'b1;
        mem_wr_addr = idx - AW'(1);
        if (idx == last) begin
          cnt_next   = cnt - CW'(1);
          state_next = S_DONE;
        end else begin
          mem_rd      = 1'b1;
          mem_rd_addr = idx + AW'(1);
          idx_next    = idx + AW'(1);
        end
      end
      S_READ: begin
        res_data_next = mem_rd_data;
        state_next    = S_DONE;
      end
      S_DONE: begin
        if (res_take) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    idx        <= idx_next;
    tgt        <= tgt_next;
    val        <= val_next;
    res_status <= res_status_next;
    res_data   <= res_data_next;
  end

  assign in_stall   = (state != S_IDLE);
  assign res_valid  = (state == S_DONE);
  assign res.status = res_status;
  assign res.data   = res_data;
  assign res.count  = iss_pkg::COUNT_W'(cnt);

  `ISS_ASSERT_IMP(a_cnt_bound, clk, rst, 1'b1, cnt_e <= CAP_E)
  `ISS_ASSERT_IMP(a_port_clash, clk, rst, mem_wr && mem_rd, mem_wr_addr != mem_rd_addr)
  `ISS_ASSERT_NXT(a_one_at_a_time, clk, rst, in_valid && !in_stall, in_stall)
  `ISS_ASSERT_NXT(a_cnt_hold, clk, rst, state == S_DONE, $stable(cnt))

endmodule

// ----- hdl/indexed_sequence_store.sv -----
// Indexed sequence store: an ordered list of signed 32-bit values with
// positional insert, read and delete, held in a single-port-pair memory.
//
// Input channel (in_valid / in_stall): req_type, position, data_in. A beat
// is taken when in_valid is high and in_stall low. One request is worked
// at a time; in_stall stays high until its result has moved to the output
// register.
// Output channel (out_valid / out_stall): status, data_out, entry_count,
// exactly one beat per request, held stable while out_stall is high.
// Path from accept to out_valid: checks that fail, an append and a delete
// of the last entry go straight to the result; a read passes through the
// read state; an insert at position p shifts the entries from the last
// down to p and then writes the new value, and a delete at p shifts the
// entries above p down by one. Each moved entry costs one memory read and
// one write, pipelined one entry per cycle. The next request is taken in
// the cycle after a result enters the output register.
// Reset clears the count and the control; memory contents need no reset.
// While the output register is full and stalled, a finished result waits
// in the sequencer and no new request is taken.
`timescale 1ns / 1ps

module indexed_sequence_store #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [2:0]                          req_type,
  input  logic [iss_pkg::POS_W-1:0]           position,
  input  logic signed [iss_pkg::DATA_W-1:0]   data_in,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          status,
  output logic signed [iss_pkg::DATA_W-1:0]   data_out,
  output logic [iss_pkg::COUNT_W-1:0]         entry_count
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic                         mem_wr, mem_rd;
  logic [AW-1:0]                mem_wr_addr, mem_rd_addr;
  logic [iss_pkg::DATA_W-1:0]   mem_wr_data, mem_rd_data;
  logic                         res_valid, res_take;
  iss_pkg::res_t                res, out_res;

  iss_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  iss_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req_type    (req_type),
    .position    (position),
    .data_in     (data_in),
    .res_valid   (res_valid),
    .res_take    (res_take),
    .res         (res),
    .mem_wr      (mem_wr),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd      (mem_rd),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  // output register: free when empty or being drained this cycle
  assign res_take = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res_valid) begin
      out_res <= res;
    end
  end

  assign status      = out_res.status;
  assign data_out    = out_res.data;
  assign entry_count = out_res.count;

endmodule
